// File: rtl/indexed_insert_delete_array_top_macros.svh
// Assertion macros for the indexed insert/delete array list.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef INDEXED_INSERT_DELETE_ARRAY_TOP_MACROS_SVH
`define INDEXED_INSERT_DELETE_ARRAY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIDA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array list.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package iida_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 2;
	localparam int IDX_W         = 5;
	localparam int CAP_W         = 5;
	localparam int POS_W         = 4;
	localparam int STATUS_W      = 2;
	localparam int MAX_RESULTS   = 16;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes carried by cmd.
	typedef enum logic [CMD_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_DISPLAY = 2'd3
	} iida_op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} iida_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic disp_step;
	} iida_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic disp_go;
		logic disp_last;
	} iida_sts_t;

endpackage

// File: rtl/indexed_insert_delete_array_top.sv
// Indexed insert/delete array list: usage.
// Request channel (req_valid, req_stall, cmd, index, value) takes one command
// per beat; a beat is taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid, rsp_stall, status, data, position, last) gives
// one result per beat; last marks the final beat caused by a command.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the capacity
// register; cfg_ready is always high, and writes belong only to idle periods.
// Insert, remove and update capture the command in the idle state, then in the
// execute state shift the cell row in parallel and load the result register.
// Display shows at most 16 entries, one entry per cycle while rsp_stall is low,
// since the single cell read port feeds the result register once a cycle.
// The result register lets a new command be taken while a result still waits.
// When the receiver holds rsp_stall, the result holds and the controller waits
// before producing the next beat; no beat is lost.
// Reset clears the fill count, sets capacity to 16 and empties the response
// channel; the cells are not cleared, as entries are read only below the count.
// Files: iida_pkg, iida_ctrl, iida_dp and the assertion macro header.
`timescale 1ns / 1ps

module indexed_insert_delete_array_top #(
	parameter int DEPTH = iida_pkg::DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [iida_pkg::CMD_W-1:0]           cmd,
	input  logic [iida_pkg::IDX_W-1:0]           index,
	input  logic signed [iida_pkg::DATA_W-1:0]   value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iida_pkg::CAP_W-1:0]           cfg_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [iida_pkg::STATUS_W-1:0]        status,
	output logic signed [iida_pkg::DATA_W-1:0]   data,
	output logic [iida_pkg::POS_W-1:0]           position,
	output logic                                 last
);
	import iida_pkg::*;

`include "indexed_insert_delete_array_top_macros.svh"

	iida_ctl_t ctl;
	iida_sts_t sts;

	// The capacity register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	iida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	iida_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.index     (index),
		.value     (value),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data      (data),
		.position  (position),
		.last      (last)
	);

	// A taken command keeps the request side busy in the following cycle.
	`IIDA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted twice")

	// A display beat that is not the final one means the command is still running.
	`IIDA_ASSERT_SAME(a_busy_mid_display, rsp_valid && !last, req_stall, "idle mid display")

endmodule

// File: rtl/iida_ctrl.sv
// Controller state machine for the indexed insert/delete array list.
// Depends on iida_pkg for the command and status structs.
`timescale 1ns / 1ps

module iida_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  iida_pkg::iida_sts_t sts,
	output iida_pkg::iida_ctl_t ctl
);
	import iida_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DISP = 3'b100
	} iida_state_t;

	iida_state_t state_q, state_d;

	// Next state and command decode.
	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					if (sts.disp_go) begin
						state_d = S_DISP;
					end else begin
						ctl.exec = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_DISP: begin
				if (sts.out_free) begin
					ctl.disp_step = 1'b1;
					if (sts.disp_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/iida_dp.sv
// Datapath for the indexed insert/delete array list: shifting cells, fill count,
// capacity register, display pointer and result register. Depends on iida_pkg.
`timescale 1ns / 1ps

module iida_dp #(
	parameter int DEPTH = iida_pkg::DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iida_pkg::iida_ctl_t                  ctl,
	output iida_pkg::iida_sts_t                  sts,
	input  logic [iida_pkg::CMD_W-1:0]           cmd,
	input  logic [iida_pkg::IDX_W-1:0]           index,
	input  logic signed [iida_pkg::DATA_W-1:0]   value,
	input  logic                                 cfg_write,
	input  logic [iida_pkg::CAP_W-1:0]           cfg_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [iida_pkg::STATUS_W-1:0]        status,
	output logic signed [iida_pkg::DATA_W-1:0]   data,
	output logic [iida_pkg::POS_W-1:0]           position,
	output logic                                 last
);
	import iida_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam int PW   = $clog2(MAX_RESULTS);

	logic [CMD_W-1:0]         op_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic [CAP_W-1:0]         cap_q;
	logic [PW-1:0]            ptr_q;
	logic signed [DATA_W-1:0] cells_q [DEPTH];

	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] data_q;
	logic [POS_W-1:0]         position_q;
	logic                     last_q;

	logic [CMPW-1:0]          count_x, idx_x, cap_x, depth_x, limit_x, ndisp_x;
	logic                     is_full, ins_bad, idx_bad;
	logic                     do_ins, do_rem, do_upd;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic                     disp_last;
	logic [STATUS_W-1:0]      res_status;
	logic signed [DATA_W-1:0] res_data;
	logic [POS_W-1:0]         res_pos;

	// Range checks against the fill count and the limit in use.
	always_comb begin
		count_x = CMPW'(count_q);
		idx_x   = CMPW'(idx_q);
		cap_x   = CMPW'(cap_q);
		depth_x = CMPW'(DEPTH);
		limit_x = (cap_x < depth_x) ? cap_x : depth_x;
		ndisp_x = (count_x < CMPW'(MAX_RESULTS)) ? count_x : CMPW'(MAX_RESULTS);
		is_full = count_x >= limit_x;
		ins_bad = idx_x > count_x;
		idx_bad = idx_x >= count_x;
	end

	// Edit enables for the cells and the count.
	assign do_ins = ctl.exec && (op_q == OP_INSERT) && !is_full && !ins_bad;
	assign do_rem = ctl.exec && (op_q == OP_REMOVE) && !idx_bad;
	assign do_upd = ctl.exec && (op_q == OP_UPDATE) && !idx_bad;

	// Single read port: the display pointer during display, else the item index.
	assign rd_addr   = ctl.disp_step ? AW'(ptr_q) : AW'(idx_x);
	assign rd_data   = cells_q[rd_addr];
	assign disp_last = (CMPW'(ptr_q) + CMPW'(1)) == ndisp_x;

	// Result of a single-beat command.
	always_comb begin
		res_status = ST_BADPOS;
		res_data   = '0;
		res_pos    = '0;
		case (op_q)
			OP_INSERT: begin
				if (is_full) begin
					res_status = ST_FULL;
				end else if (!ins_bad) begin
					res_status = ST_OK;
					res_data   = val_q;
					res_pos    = POS_W'(idx_q);
				end
			end
			OP_REMOVE, OP_UPDATE: begin
				if (!idx_bad) begin
					res_status = ST_OK;
					res_data   = rd_data;
					res_pos    = POS_W'(idx_q);
				end
			end
			OP_DISPLAY: begin
				res_status = ST_EMPTY;
			end
			default: begin
				res_status = ST_BADPOS;
			end
		endcase
	end

	// Shifting cells: each cell takes its lower or upper neighbor, or the new word.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] below_d, above_d;

		if (g == 0) begin : g_first
			assign below_d = val_q;
		end else begin : g_mid_lo
			assign below_d = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign above_d = cells_q[g];
		end else begin : g_mid_hi
			assign above_d = cells_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (do_ins && (CMPW'(g) > idx_x)) begin
				cells_q[g] <= below_d;
			end else if ((do_ins || do_upd) && (CMPW'(g) == idx_x)) begin
				cells_q[g] <= val_q;
			end else if (do_rem && (CMPW'(g) >= idx_x)) begin
				cells_q[g] <= above_d;
			end
		end
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd;
			idx_q <= index;
			val_q <= value;
		end
	end

	// Fill count, capacity register and display pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			ptr_q   <= '0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + CW'(1);
			end else if (do_rem) begin
				count_q <= count_q - CW'(1);
			end
			if (cfg_write) begin
				cap_q <= cfg_data;
			end
			if (ctl.load) begin
				ptr_q <= '0;
			end else if (ctl.disp_step) begin
				ptr_q <= ptr_q + PW'(1);
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.exec || ctl.disp_step) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q   <= res_status;
			data_q     <= res_data;
			position_q <= res_pos;
			last_q     <= 1'b1;
		end else if (ctl.disp_step) begin
			status_q   <= ST_OK;
			data_q     <= rd_data;
			position_q <= POS_W'(ptr_q);
			last_q     <= disp_last;
		end
	end

	assign sts.out_free  = !rsp_valid_q || !rsp_stall;
	assign sts.disp_go   = (op_q == OP_DISPLAY) && (count_q != '0);
	assign sts.disp_last = disp_last;

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule
